// ----- src/pws_pkg.sv -----
// Shared types and constants of the perspective world-to-screen block.
// No dependencies; every other file refers to names here by scope.
package pws_pkg;

  localparam int CoordW  = 32;   // world coordinate width, Q24.8
  localparam int CoefW   = 32;   // matrix coefficient width, Q16.16
  localparam int ClipW   = 60;   // clip value width, Q.16
  localparam int FracW   = 20;   // fraction bits of the ratio
  localparam int QuotW   = FracW + 1;
  localparam int DivStages = QuotW;
  localparam int OutW    = 17;
  localparam int SizeW   = 12;
  localparam int CfgIdxW = 8;
  localparam int CfgDataW = 64;

  typedef logic signed [ClipW-1:0] clip_t;
  typedef logic [ClipW-1:0]        mag_t;
  typedef logic [QuotW-1:0]        quot_t;
  typedef logic signed [OutW-1:0]  screen_t;

  // Depths at or below -0.01 in Q.16 lie behind the eye.
  localparam clip_t WLimit = -60'sd656;
  localparam screen_t RejCoord = -17'sd16;

  localparam logic [CfgIdxW-1:0] RegXRowLow   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegXRowHigh  = 8'd1;
  localparam logic [CfgIdxW-1:0] RegYRowLow   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegYRowHigh  = 8'd3;
  localparam logic [CfgIdxW-1:0] RegWRowLow   = 8'd4;
  localparam logic [CfgIdxW-1:0] RegWRowHigh  = 8'd5;
  localparam logic [CfgIdxW-1:0] RegScreenW   = 8'd6;
  localparam logic [CfgIdxW-1:0] RegScreenH   = 8'd7;

  localparam logic [SizeW-1:0] ScreenWReset = 12'd1920;
  localparam logic [SizeW-1:0] ScreenHReset = 12'd1080;

endpackage

// ----- src/pws_ifs.sv -----
// Channel interfaces of the projection block: point input, screen result and
// configuration write. Depends on pws_pkg for field widths.
interface pws_in_if;
  logic valid;
  logic ready;
  logic signed [pws_pkg::CoordW-1:0] world_x;
  logic signed [pws_pkg::CoordW-1:0] world_y;
  logic signed [pws_pkg::CoordW-1:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink (input valid, world_x, world_y, world_z, output ready);
endinterface

interface pws_out_if;
  logic valid;
  logic ready;
  pws_pkg::screen_t screen_x;
  pws_pkg::screen_t screen_y;
  logic on_screen;
  modport source (output valid, screen_x, screen_y, on_screen, input ready);
  modport sink (input valid, screen_x, screen_y, on_screen, output ready);
endinterface

interface pws_cfg_if;
  logic valid;
  logic ready;
  logic [pws_pkg::CfgIdxW-1:0] index;
  logic [pws_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/pws_div.sv -----
// Pipelined restoring divider: floor(n * 2^20 / d) for n <= d, one quotient
// bit per stage. Depends on pws_pkg for widths and stage count.
module pws_div (
  input  logic              clk,
  input  logic              en,
  input  pws_pkg::mag_t     n_i,
  input  pws_pkg::mag_t     d_i,
  output pws_pkg::quot_t    q_o
);

  localparam int RemW = pws_pkg::ClipW + 1;

  logic [RemW-1:0]            rem_r [pws_pkg::DivStages];
  logic [RemW-1:0]            rem_nxt [pws_pkg::DivStages];
  pws_pkg::mag_t              d_r [pws_pkg::DivStages];
  pws_pkg::quot_t             q_r [pws_pkg::DivStages];
  pws_pkg::quot_t             q_nxt [pws_pkg::DivStages];

  genvar s;
  generate
    for (s = 0; s < pws_pkg::DivStages; s++) begin : g_stage
      logic [RemW-1:0] trial;
      logic [RemW-1:0] dext;
      logic            ge;
      if (s == 0) begin : g_first
        // The leading bit needs no shift since n never exceeds d.
        assign trial = {1'b0, n_i};
        assign dext  = {1'b0, d_i};
        assign q_nxt[s] = {{(pws_pkg::QuotW-1){1'b0}}, ge};
      end else begin : g_next
        assign trial = {rem_r[s-1][RemW-2:0], 1'b0};
        assign dext  = {1'b0, d_r[s-1]};
        assign q_nxt[s] = {q_r[s-1][pws_pkg::QuotW-2:0], ge};
      end
      assign ge = (trial >= dext);
      assign rem_nxt[s] = ge ? (trial - dext) : trial;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= rem_nxt[s];
          d_r[s]   <= dext[pws_pkg::ClipW-1:0];
          q_r[s]   <= q_nxt[s];
        end
      end
    end
  endgenerate

  assign q_o = q_r[pws_pkg::DivStages-1];

endmodule

// ----- src/perspective_world_to_screen_top.sv -----
// Perspective world-to-screen projection. A point enters every clock cycle
// while the output is not stalled and passes 25 register stages: one stage of
// nine 32x32 products, one of row sums, one of range checks, 21 stages of the
// two quotient dividers (one quotient bit per stage) and one viewport mapping
// stage that is also the output register. The whole pipeline holds while the
// output is stalled. Registers are to be written by the user only while no
// point is in flight, since the row sums read the offsets and the mapping stage
// reads the viewport sizes from the live registers. The block itself does not
// enforce this. Depends on pws_pkg, pws_ifs and pws_div.
module perspective_world_to_screen_top (
  input  logic           clk,
  input  logic           rst_n,
  pws_in_if.sink         in_ch,
  pws_out_if.source      out_ch,
  pws_cfg_if.sink        cfg_ch
);

  localparam int ND = pws_pkg::DivStages;

  logic [63:0] x_lo_r, x_hi_r, y_lo_r, y_hi_r, w_lo_r, w_hi_r;
  logic [pws_pkg::SizeW-1:0] scr_w_r, scr_h_r;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lo_r <= '0; x_hi_r <= '0; y_lo_r <= '0; y_hi_r <= '0;
      w_lo_r <= '0; w_hi_r <= '0;
      scr_w_r <= pws_pkg::ScreenWReset;
      scr_h_r <= pws_pkg::ScreenHReset;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        pws_pkg::RegXRowLow:  x_lo_r <= cfg_ch.data;
        pws_pkg::RegXRowHigh: x_hi_r <= cfg_ch.data;
        pws_pkg::RegYRowLow:  y_lo_r <= cfg_ch.data;
        pws_pkg::RegYRowHigh: y_hi_r <= cfg_ch.data;
        pws_pkg::RegWRowLow:  w_lo_r <= cfg_ch.data;
        pws_pkg::RegWRowHigh: w_hi_r <= cfg_ch.data;
        pws_pkg::RegScreenW:  scr_w_r <= cfg_ch.data[pws_pkg::SizeW-1:0];
        pws_pkg::RegScreenH:  scr_h_r <= cfg_ch.data[pws_pkg::SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: products, exact Q.24.
  logic signed [63:0] p_r [9];
  logic               v1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= $signed(x_lo_r[31:0])  * in_ch.world_x;
      p_r[1] <= $signed(x_lo_r[63:32]) * in_ch.world_y;
      p_r[2] <= $signed(x_hi_r[31:0])  * in_ch.world_z;
      p_r[3] <= $signed(y_lo_r[31:0])  * in_ch.world_x;
      p_r[4] <= $signed(y_lo_r[63:32]) * in_ch.world_y;
      p_r[5] <= $signed(y_hi_r[31:0])  * in_ch.world_z;
      p_r[6] <= $signed(w_lo_r[31:0])  * in_ch.world_x;
      p_r[7] <= $signed(w_lo_r[63:32]) * in_ch.world_y;
      p_r[8] <= $signed(w_hi_r[31:0])  * in_ch.world_z;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
  end

  // Stage 2: floor of the row sum to Q.16, plus the offset.
  logic signed [65:0] sx, sy, sw;
  pws_pkg::clip_t cx_nxt, cy_nxt, cw_nxt, cx_r, cy_r, cw_r;
  logic v2_r;
  always_comb begin
    sx = 66'(p_r[0]) + 66'(p_r[1]) + 66'(p_r[2]);
    sy = 66'(p_r[3]) + 66'(p_r[4]) + 66'(p_r[5]);
    sw = 66'(p_r[6]) + 66'(p_r[7]) + 66'(p_r[8]);
    cx_nxt = pws_pkg::ClipW'(sx >>> 8) + pws_pkg::ClipW'($signed(x_hi_r[63:32]));
    cy_nxt = pws_pkg::ClipW'(sy >>> 8) + pws_pkg::ClipW'($signed(y_hi_r[63:32]));
    cw_nxt = pws_pkg::ClipW'(sw >>> 8) + pws_pkg::ClipW'($signed(w_hi_r[63:32]));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cw_r <= cw_nxt;
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  // Stage 3: magnitudes, signs and rejection.
  pws_pkg::mag_t mx_nxt, my_nxt, mw_nxt, mx_r, my_r, mw_r;
  logic rej_nxt, rej_r, nx_r, ny_r, v3_r;
  always_comb begin
    mx_nxt = cx_r[pws_pkg::ClipW-1] ? pws_pkg::mag_t'(-cx_r) : pws_pkg::mag_t'(cx_r);
    my_nxt = cy_r[pws_pkg::ClipW-1] ? pws_pkg::mag_t'(-cy_r) : pws_pkg::mag_t'(cy_r);
    mw_nxt = cw_r[pws_pkg::ClipW-1] ? pws_pkg::mag_t'(-cw_r) : pws_pkg::mag_t'(cw_r);
    rej_nxt = (cw_r <= pws_pkg::WLimit) || (cw_r == '0) ||
              (mx_nxt > mw_nxt) || (my_nxt > mw_nxt);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
      mw_r <= mw_nxt;
      rej_r <= rej_nxt;
      nx_r <= cx_r[pws_pkg::ClipW-1] != cw_r[pws_pkg::ClipW-1];
      ny_r <= cy_r[pws_pkg::ClipW-1] != cw_r[pws_pkg::ClipW-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  // Divider stages, with flags carried alongside.
  pws_pkg::quot_t qx, qy;
  pws_div u_div_x (.clk(clk), .en(en), .n_i(mx_r), .d_i(mw_r), .q_o(qx));
  pws_div u_div_y (.clk(clk), .en(en), .n_i(my_r), .d_i(mw_r), .q_o(qy));

  logic vd_r [ND];
  logic rd_r [ND];
  logic nxd_r [ND];
  logic nyd_r [ND];
  always_ff @(posedge clk) begin
    if (en) begin
      rd_r[0] <= rej_r;
      nxd_r[0] <= nx_r;
      nyd_r[0] <= ny_r;
      for (int i = 1; i < ND; i++) begin
        rd_r[i] <= rd_r[i-1];
        nxd_r[i] <= nxd_r[i-1];
        nyd_r[i] <= nyd_r[i-1];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ND; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v3_r;
      for (int i = 1; i < ND; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  // Output stage: viewport mapping, y axis flipped.
  localparam int NumW = pws_pkg::FracW + 2;
  localparam int ProdW = pws_pkg::SizeW + 3 + NumW;
  localparam logic [NumW-1:0] One = NumW'(1) << pws_pkg::FracW;
  localparam logic [ProdW-1:0] Half = ProdW'(1) << (pws_pkg::FracW - 1);
  logic [NumW-1:0] numx, numy;
  logic [ProdW-1:0] prodx, prody;
  pws_pkg::screen_t sx_nxt, sy_nxt, sx_r, sy_r;
  logic on_r, vo_r;
  always_comb begin
    numx = nxd_r[ND-1] ? (One - NumW'(qx)) : (One + NumW'(qx));
    numy = nyd_r[ND-1] ? (One + NumW'(qy)) : (One - NumW'(qy));
    prodx = ProdW'({scr_w_r, 3'b000}) * ProdW'(numx) + Half;
    prody = ProdW'({scr_h_r, 3'b000}) * ProdW'(numy) + Half;
    if (rd_r[ND-1]) begin
      sx_nxt = pws_pkg::RejCoord;
      sy_nxt = pws_pkg::RejCoord;
    end else begin
      sx_nxt = prodx[pws_pkg::FracW +: pws_pkg::OutW];
      sy_nxt = prody[pws_pkg::FracW +: pws_pkg::OutW];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      on_r <= !rd_r[ND-1];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= vd_r[ND-1];
  end

  assign out_ch.valid = vo_r;
  assign out_ch.screen_x = sx_r;
  assign out_ch.screen_y = sy_r;
  assign out_ch.on_screen = on_r;

endmodule
